/* rtl/abdtd_pkg.sv */
// abdtd_pkg: shared types and constants for the arcade bus decoder with tile dirty map
// holds memory map boundaries, function and register codes, state and command types
// no dependencies
package abdtd_pkg;

   // bus function codes
   localparam logic [1:0] FUNC_CPU_READ   = 2'd0;
   localparam logic [1:0] FUNC_CPU_WRITE  = 2'd1;
   localparam logic [1:0] FUNC_VIDEO_READ = 2'd2;

   // configuration register indexes
   localparam logic CSR_DIP_A = 1'b0;
   localparam logic CSR_DIP_B = 1'b1;

   // storage geometry
   localparam int RAM_DEPTH  = 4096;
   localparam int RAM_AW     = 12;
   localparam int MAP_DEPTH  = 1024;
   localparam int MAP_AW     = 10;
   localparam int SPR_DEPTH  = 16;
   localparam int SPR_AW     = 4;
   localparam int DATA_W     = 8;
   localparam int LATCH_W    = 6;
   localparam int SREG_W     = 5;

   // memory map
   localparam logic [15:0] ROM_TOP     = 16'h7fff;
   localparam logic [15:0] VRAM_TOP    = 16'h87ff;
   localparam logic [15:0] RAM_TOP     = 16'h8fff;
   localparam logic [15:0] SND_TOP     = 16'h901f;
   localparam logic [15:0] SPR_BASE    = 16'h9020;
   localparam logic [15:0] SPR_TOP     = 16'h902f;
   localparam logic [15:0] DIP_B_TOP   = 16'h903f;
   localparam logic [15:0] DIP_A_TOP   = 16'h907f;
   localparam logic [15:0] START_TOP   = 16'h90bf;
   localparam logic [15:0] JOY_TOP     = 16'h90ff;
   localparam logic [15:0] LATCH_IRQ   = 16'h9040;
   localparam logic [15:0] LATCH_SOUND = 16'h9041;
   localparam logic [15:0] LATCH_PAL   = 16'h9042;
   localparam logic [15:0] LATCH_FLIP  = 16'h9043;
   localparam logic [15:0] LATCH_CTAB  = 16'h9046;
   localparam logic [15:0] LATCH_GFX   = 16'h9047;

   localparam logic [DATA_W-1:0] OPEN_BUS = 8'hff;

   typedef enum logic [1:0] {
      ST_CLEAR,
      ST_IDLE,
      ST_EXEC,
      ST_MARK
   } state_type;

   typedef struct packed {
      logic idle;       // read ports follow the request channel
      logic accept;     // capture a request word
      logic exec;       // commit the access and load the response word
      logic sweep;      // sweep counter drives the write ports
      logic sweep_ram;  // sweep also clears work ram
   } cmd_type;

   typedef struct packed {
      logic mark_req;   // committed access changes a bank latch
      logic ram_last;   // sweep counter at last work ram entry
      logic map_last;   // sweep counter at last dirty map entry
   } status_type;

endpackage

/* rtl/abdtd_ram.sv */
// abdtd_ram: generic simple dual-port ram, one write and one registered read port
// used for work ram and the tile dirty map
// no dependencies
module abdtd_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 4096
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

/* rtl/abdtd_ctrl.sv */
// abdtd_ctrl: sequencing state machine for the bus decoder
// clearing pass, request capture, commit, mark-all sweep, response valid
// depends on abdtd_pkg
module abdtd_ctrl (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_valid,
   output logic                   req_stall,
   output logic                   rsp_valid,
   input  logic                   rsp_stall,
   input  abdtd_pkg::status_type  status,
   output abdtd_pkg::cmd_type     cmd
);

   abdtd_pkg::state_type state_ff, state_in;
   logic rsp_valid_ff, rsp_valid_in;
   logic out_free;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= abdtd_pkg::ST_CLEAR;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   assign out_free = !rsp_valid_ff || !rsp_stall;

   always_comb begin
      state_in  = state_ff;
      cmd       = '0;
      req_stall = 1'b1;
      case (state_ff)
         abdtd_pkg::ST_CLEAR: begin
            cmd.sweep     = 1'b1;
            cmd.sweep_ram = 1'b1;
            if (status.ram_last) begin
               state_in = abdtd_pkg::ST_IDLE;
            end
         end
         abdtd_pkg::ST_IDLE: begin
            cmd.idle   = 1'b1;
            req_stall  = 1'b0;
            cmd.accept = req_valid;
            if (req_valid) begin
               state_in = abdtd_pkg::ST_EXEC;
            end
         end
         abdtd_pkg::ST_EXEC: begin
            // wait for the response register to free up
            if (out_free) begin
               cmd.exec = 1'b1;
               state_in = status.mark_req ? abdtd_pkg::ST_MARK : abdtd_pkg::ST_IDLE;
            end
         end
         abdtd_pkg::ST_MARK: begin
            cmd.sweep = 1'b1;
            if (status.map_last) begin
               state_in = abdtd_pkg::ST_IDLE;
            end
         end
         default: begin
            state_in = abdtd_pkg::ST_IDLE;
         end
      endcase
      rsp_valid_in = cmd.exec | (rsp_valid_ff & rsp_stall);
   end

   assign rsp_valid = rsp_valid_ff;

endmodule

/* rtl/abdtd_dp.sv */
// abdtd_dp: datapath of the bus decoder
// request capture, work ram and dirty map, sprite store, latches, switches, response word
// depends on abdtd_pkg and abdtd_ram
module abdtd_dp (
   input  logic                                   clock,
   input  logic                                   reset,
   input  abdtd_pkg::cmd_type                     cmd,
   output abdtd_pkg::status_type                  status,
   input  logic                                   csr_write_enable,
   input  logic                                   csr_index,
   input  logic [abdtd_pkg::DATA_W-1:0]           csr_write_data,
   input  logic [1:0]                             req_func,
   input  logic [15:0]                            req_bus_address,
   input  logic [abdtd_pkg::DATA_W-1:0]           req_write_value,
   input  logic                                   req_opcode_cycle,
   input  logic [abdtd_pkg::DATA_W-1:0]           req_joystick_port,
   input  logic [abdtd_pkg::DATA_W-1:0]           req_start_port,
   output logic [abdtd_pkg::DATA_W-1:0]           rsp_read_value,
   output logic                                   rsp_rom_read,
   output logic                                   rsp_rom_opcode_space,
   output logic                                   rsp_sound_write,
   output logic [abdtd_pkg::SREG_W-1:0]           rsp_sound_reg,
   output logic [abdtd_pkg::DATA_W-1:0]           rsp_sound_data,
   output logic                                   rsp_irq_clear,
   output logic [abdtd_pkg::LATCH_W-1:0]          rsp_latch_bits,
   output logic                                   rsp_tile_dirty
);

   localparam int DW = abdtd_pkg::DATA_W;

   // captured request word
   logic [1:0]    func_ff;
   logic [15:0]   addr_ff;
   logic [DW-1:0] wval_ff;
   logic          opc_ff;
   logic [DW-1:0] joy_ff;
   logic [DW-1:0] start_ff;

   logic [DW-1:0] dip_a_ff, dip_b_ff;
   logic [DW-1:0] spr_ff [abdtd_pkg::SPR_DEPTH];
   logic [abdtd_pkg::RAM_AW-1:0] sweep_cnt_ff;

   logic irq_ff, snd_en_ff, pal_ff, flip_ff, ctab_ff, gfx_ff;
   logic irq_in, snd_en_in, pal_in, flip_in, ctab_in, gfx_in;

   // response register
   logic [DW-1:0]                     rd_ff;
   logic                              rom_ff, ospace_ff, snd_ff, irqc_ff, dirty_ff;
   logic [abdtd_pkg::SREG_W-1:0]      sreg_ff;
   logic [DW-1:0]                     sdat_ff;

   logic [DW-1:0]                     rd_in;
   logic                              rom_in, ospace_in, snd_in, irqc_in, dirty_in;
   logic [abdtd_pkg::SREG_W-1:0]      sreg_in;
   logic [DW-1:0]                     sdat_in;

   logic ram_we_c, map_we_c, map_bit_c, spr_we_c;

   logic                         ram_we;
   logic [abdtd_pkg::RAM_AW-1:0] ram_waddr, ram_raddr;
   logic [DW-1:0]                ram_wdata, ram_rdata;
   logic                         map_we;
   logic [abdtd_pkg::MAP_AW-1:0] map_waddr, map_raddr;
   logic [0:0]                   map_wdata, map_rdata;

   always_ff @(posedge clock) begin
      if (cmd.accept) begin
         func_ff  <= req_func;
         addr_ff  <= req_bus_address;
         wval_ff  <= req_write_value;
         opc_ff   <= req_opcode_cycle;
         joy_ff   <= req_joystick_port;
         start_ff <= req_start_port;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         dip_a_ff <= '0;
         dip_b_ff <= '0;
      end else if (csr_write_enable) begin
         case (csr_index)
            abdtd_pkg::CSR_DIP_A: dip_a_ff <= csr_write_data;
            abdtd_pkg::CSR_DIP_B: dip_b_ff <= csr_write_data;
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         sweep_cnt_ff <= '0;
      end else if (cmd.sweep) begin
         sweep_cnt_ff <= sweep_cnt_ff + 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < abdtd_pkg::SPR_DEPTH; i++) begin
            spr_ff[i] <= '0;
         end
      end else if (cmd.exec && spr_we_c) begin
         spr_ff[addr_ff[abdtd_pkg::SPR_AW-1:0]] <= wval_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         irq_ff    <= 1'b0;
         snd_en_ff <= 1'b0;
         pal_ff    <= 1'b0;
         flip_ff   <= 1'b0;
         ctab_ff   <= 1'b0;
         gfx_ff    <= 1'b0;
      end else if (cmd.exec) begin
         irq_ff    <= irq_in;
         snd_en_ff <= snd_en_in;
         pal_ff    <= pal_in;
         flip_ff   <= flip_in;
         ctab_ff   <= ctab_in;
         gfx_ff    <= gfx_in;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.exec) begin
         rd_ff     <= rd_in;
         rom_ff    <= rom_in;
         ospace_ff <= ospace_in;
         snd_ff    <= snd_in;
         sreg_ff   <= sreg_in;
         sdat_ff   <= sdat_in;
         irqc_ff   <= irqc_in;
         dirty_ff  <= dirty_in;
      end
   end

   // decode of the captured access against the ram and map read data
   always_comb begin
      rd_in     = '0;
      rom_in    = 1'b0;
      ospace_in = 1'b0;
      snd_in    = 1'b0;
      sreg_in   = '0;
      sdat_in   = '0;
      irqc_in   = 1'b0;
      dirty_in  = 1'b0;
      ram_we_c  = 1'b0;
      map_we_c  = 1'b0;
      map_bit_c = 1'b0;
      spr_we_c  = 1'b0;
      irq_in    = irq_ff;
      snd_en_in = snd_en_ff;
      pal_in    = pal_ff;
      flip_in   = flip_ff;
      ctab_in   = ctab_ff;
      gfx_in    = gfx_ff;
      case (func_ff)
         abdtd_pkg::FUNC_CPU_READ: begin
            if (addr_ff <= abdtd_pkg::ROM_TOP) begin
               rd_in     = abdtd_pkg::OPEN_BUS;
               rom_in    = 1'b1;
               ospace_in = opc_ff;
            end else if (addr_ff <= abdtd_pkg::RAM_TOP) begin
               rd_in = ram_rdata;
            end else if (addr_ff <= abdtd_pkg::DIP_B_TOP) begin
               rd_in = dip_b_ff;
            end else if (addr_ff <= abdtd_pkg::DIP_A_TOP) begin
               rd_in = dip_a_ff;
            end else if (addr_ff <= abdtd_pkg::START_TOP) begin
               rd_in = start_ff;
            end else if (addr_ff <= abdtd_pkg::JOY_TOP) begin
               rd_in = joy_ff;
            end else begin
               rd_in = abdtd_pkg::OPEN_BUS;
            end
         end
         abdtd_pkg::FUNC_CPU_WRITE: begin
            if (addr_ff <= abdtd_pkg::ROM_TOP) begin
               rd_in = '0;
            end else if (addr_ff <= abdtd_pkg::VRAM_TOP) begin
               // video ram marks its tile only on a changed byte
               if (ram_rdata != wval_ff) begin
                  ram_we_c  = 1'b1;
                  map_we_c  = 1'b1;
                  map_bit_c = 1'b1;
               end
            end else if (addr_ff <= abdtd_pkg::RAM_TOP) begin
               ram_we_c = 1'b1;
            end else if (addr_ff <= abdtd_pkg::SND_TOP) begin
               snd_in  = 1'b1;
               sreg_in = addr_ff[abdtd_pkg::SREG_W-1:0];
               sdat_in = wval_ff;
            end else if (addr_ff <= abdtd_pkg::SPR_TOP) begin
               spr_we_c = 1'b1;
            end else begin
               case (addr_ff)
                  abdtd_pkg::LATCH_IRQ: begin
                     irq_in  = (wval_ff != '0);
                     irqc_in = (wval_ff == '0);
                  end
                  abdtd_pkg::LATCH_SOUND: snd_en_in = (wval_ff != '0);
                  abdtd_pkg::LATCH_PAL:   pal_in    = wval_ff[0];
                  abdtd_pkg::LATCH_FLIP:  flip_in   = wval_ff[0];
                  abdtd_pkg::LATCH_CTAB:  ctab_in   = wval_ff[0];
                  abdtd_pkg::LATCH_GFX:   gfx_in    = wval_ff[0];
                  default: ;
               endcase
            end
         end
         abdtd_pkg::FUNC_VIDEO_READ: begin
            if (addr_ff >= abdtd_pkg::SPR_BASE && addr_ff <= abdtd_pkg::SPR_TOP) begin
               rd_in = spr_ff[addr_ff[abdtd_pkg::SPR_AW-1:0]];
            end else begin
               // test and clear
               rd_in     = ram_rdata;
               dirty_in  = map_rdata[0];
               map_we_c  = 1'b1;
               map_bit_c = 1'b0;
            end
         end
         default: begin
            rd_in = abdtd_pkg::OPEN_BUS;
         end
      endcase
   end

   assign status.mark_req = (pal_in != pal_ff) | (ctab_in != ctab_ff) | (gfx_in != gfx_ff);
   assign status.ram_last = (sweep_cnt_ff == {abdtd_pkg::RAM_AW{1'b1}});
   assign status.map_last = (sweep_cnt_ff[abdtd_pkg::MAP_AW-1:0] == {abdtd_pkg::MAP_AW{1'b1}});

   // read ports follow the request channel while idle so data lands with the commit
   assign ram_raddr = cmd.idle ? req_bus_address[abdtd_pkg::RAM_AW-1:0]
                               : addr_ff[abdtd_pkg::RAM_AW-1:0];
   assign map_raddr = cmd.idle ? req_bus_address[abdtd_pkg::MAP_AW-1:0]
                               : addr_ff[abdtd_pkg::MAP_AW-1:0];

   assign ram_we    = (cmd.sweep & cmd.sweep_ram) | (cmd.exec & ram_we_c);
   assign ram_waddr = cmd.sweep ? sweep_cnt_ff : addr_ff[abdtd_pkg::RAM_AW-1:0];
   assign ram_wdata = cmd.sweep ? '0 : wval_ff;

   assign map_we    = cmd.sweep | (cmd.exec & map_we_c);
   assign map_waddr = cmd.sweep ? sweep_cnt_ff[abdtd_pkg::MAP_AW-1:0]
                                : addr_ff[abdtd_pkg::MAP_AW-1:0];
   assign map_wdata = cmd.sweep ? 1'b1 : map_bit_c;

   abdtd_ram #(
      .WIDTH (DW),
      .DEPTH (abdtd_pkg::RAM_DEPTH)
   ) u_work_ram (
      .clock   (clock),
      .wr_en   (ram_we),
      .wr_addr (ram_waddr),
      .wr_data (ram_wdata),
      .rd_addr (ram_raddr),
      .rd_data (ram_rdata)
   );

   abdtd_ram #(
      .WIDTH (1),
      .DEPTH (abdtd_pkg::MAP_DEPTH)
   ) u_dirty_map (
      .clock   (clock),
      .wr_en   (map_we),
      .wr_addr (map_waddr),
      .wr_data (map_wdata),
      .rd_addr (map_raddr),
      .rd_data (map_rdata)
   );

   assign rsp_read_value       = rd_ff;
   assign rsp_rom_read         = rom_ff;
   assign rsp_rom_opcode_space = ospace_ff;
   assign rsp_sound_write      = snd_ff;
   assign rsp_sound_reg        = sreg_ff;
   assign rsp_sound_data       = sdat_ff;
   assign rsp_irq_clear        = irqc_ff;
   assign rsp_tile_dirty       = dirty_ff;
   assign rsp_latch_bits       = {gfx_ff, ctab_ff, flip_ff, pal_ff, snd_en_ff, irq_ff};

endmodule

/* rtl/arcade_bus_decoder_tile_dirty.sv */
// arcade_bus_decoder_tile_dirty: arcade memory map decoder with per-tile dirty tracking
// top level joining the controller and the datapath
// depends on abdtd_pkg, abdtd_ctrl, abdtd_dp, abdtd_ram
//
// usage:
// - req channel carries one bus access word (function, address, write byte, opcode flag,
//   joystick and start port bytes); rsp channel returns one decoded word per access
// - a word is taken when valid is high and stall is low; stall marks the receiver busy
// - csr port writes the two dip switch banks at any time the block is idle
// - the response word is registered at the commit, which follows the request capture once the
//   output register is free
// - a new access is taken only after the last one is committed, since the registered read of
//   the work ram and dirty map is followed by the commit
// - a write that changes the palette, colortable or gfx bank latch starts a sweep that sets
//   all 1024 dirty bits, one per cycle, before the next request is taken
// - after reset the block runs a clearing pass over all of work ram (zero) and the dirty
//   map (all ones) with req_stall high; csr writes are taken during the pass
// - a stalled response holds in its output register; the block may take the next request
//   meanwhile and waits to commit it until the output register frees up
module arcade_bus_decoder_tile_dirty (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 csr_write_enable,
   input  logic                                 csr_index,
   input  logic [abdtd_pkg::DATA_W-1:0]         csr_write_data,
   input  logic                                 req_valid,
   output logic                                 req_stall,
   input  logic [1:0]                           req_func,
   input  logic [15:0]                          req_bus_address,
   input  logic [abdtd_pkg::DATA_W-1:0]         req_write_value,
   input  logic                                 req_opcode_cycle,
   input  logic [abdtd_pkg::DATA_W-1:0]         req_joystick_port,
   input  logic [abdtd_pkg::DATA_W-1:0]         req_start_port,
   output logic                                 rsp_valid,
   input  logic                                 rsp_stall,
   output logic [abdtd_pkg::DATA_W-1:0]         rsp_read_value,
   output logic                                 rsp_rom_read,
   output logic                                 rsp_rom_opcode_space,
   output logic                                 rsp_sound_write,
   output logic [abdtd_pkg::SREG_W-1:0]         rsp_sound_reg,
   output logic [abdtd_pkg::DATA_W-1:0]         rsp_sound_data,
   output logic                                 rsp_irq_clear,
   output logic [abdtd_pkg::LATCH_W-1:0]        rsp_latch_bits,
   output logic                                 rsp_tile_dirty
);

   abdtd_pkg::cmd_type    cmd;
   abdtd_pkg::status_type status;

   abdtd_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .status    (status),
      .cmd       (cmd)
   );

   abdtd_dp u_dp (
      .clock                (clock),
      .reset                (reset),
      .cmd                  (cmd),
      .status               (status),
      .csr_write_enable     (csr_write_enable),
      .csr_index            (csr_index),
      .csr_write_data       (csr_write_data),
      .req_func             (req_func),
      .req_bus_address      (req_bus_address),
      .req_write_value      (req_write_value),
      .req_opcode_cycle     (req_opcode_cycle),
      .req_joystick_port    (req_joystick_port),
      .req_start_port       (req_start_port),
      .rsp_read_value       (rsp_read_value),
      .rsp_rom_read         (rsp_rom_read),
      .rsp_rom_opcode_space (rsp_rom_opcode_space),
      .rsp_sound_write      (rsp_sound_write),
      .rsp_sound_reg        (rsp_sound_reg),
      .rsp_sound_data       (rsp_sound_data),
      .rsp_irq_clear        (rsp_irq_clear),
      .rsp_latch_bits       (rsp_latch_bits),
      .rsp_tile_dirty       (rsp_tile_dirty)
   );

   // clearing pass holds off requests right after reset
   a_reset_stall: assert property (@(posedge clock) reset |=> req_stall)
      else $error("request taken during clearing pass");

   // a commit never overwrites a response still waiting
   a_commit_free: assert property (@(posedge clock) disable iff (reset)
      cmd.exec |-> (!rsp_valid || !rsp_stall))
      else $error("commit over a stalled response");

   // every commit shows a response word next cycle
   a_commit_rsp: assert property (@(posedge clock) disable iff (reset)
      cmd.exec |=> rsp_valid)
      else $error("commit lost its response");

   // no request accepted while a sweep drives the memories
   a_sweep_stall: assert property (@(posedge clock) disable iff (reset)
      cmd.sweep |-> (req_stall && !cmd.exec))
      else $error("request or commit during sweep");

endmodule
